### hdl/bfiq_pkg.sv
// Shared package for the Bloom filter insert/query core.
// Holds filter geometry, hash constants, operation codes and the
// controller/datapath command and status structs. No dependencies.
package bfiq_pkg;

   localparam int unsigned FILTER_BITS = 1024;
   localparam int unsigned SLOT_W      = $clog2(FILTER_BITS);

   localparam int unsigned PROBE_MAX   = 8;
   localparam int unsigned PROBE_W     = $clog2(PROBE_MAX);
   localparam int unsigned COUNT_W     = 4;

   localparam logic [63:0] HASH_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] HASH_MUL1   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] HASH_MUL2   = 64'h94d049bb133111eb;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_QUERY  = 1'b1;

   localparam logic       CSR_IDX_PROBE_COUNT = 1'b0;
   localparam logic [3:0] PROBE_COUNT_RESET   = 4'd3;

   typedef struct packed {
      logic               clear;
      logic               accept;
      logic               issue;
      logic [PROBE_W-1:0] probe;
      logic               load_rsp;
   } bfiq_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic busy;
   } bfiq_status_type;

endpackage

### hdl/bfiq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters. No dependencies.
module bfiq_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bfiq_datapath.sv
// Datapath: key latch, seven-stage probe hash pipeline, filter bit store
// access, clearing address counter and response register.
// Depends on bfiq_pkg and bfiq_ram.
module bfiq_datapath
   import bfiq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bfiq_cmd_type    cmd,
   output bfiq_status_type status,
   input  logic            req_operation,
   input  logic [31:0]     req_key,
   output logic            rsp_may_contain
);

   logic              op_ff;
   logic [31:0]       key_ff;
   logic              hit_ff;
   logic              may_ff;
   logic [SLOT_W-1:0] clr_addr_ff;

   logic [7:1]        valid_ff;
   logic              rd_valid_ff;

   logic [63:0]       s1_x_ff;
   logic [63:0]       s2_x_ff;
   logic [63:0]       s2_acc_ff;
   logic [63:0]       s3_x_ff;
   logic [63:0]       s3_acc_ff;
   logic [63:0]       s4_y_ff;
   logic [63:0]       s5_x_ff;
   logic [63:0]       s5_acc_ff;
   logic [63:0]       s6_x_ff;
   logic [63:0]       s6_acc_ff;
   logic [63:0]       s7_z_ff;

   logic [63:0]       x0;
   logic [63:0]       mix_t;
   logic [63:0]       s1_x_in;
   logic [63:0]       x2;
   logic [63:0]       prod2;
   logic [63:0]       prod3;
   logic [63:0]       prod4;
   logic [63:0]       prod5;
   logic [63:0]       prod6;
   logic [63:0]       prod7;
   logic [63:0]       z_fin;
   logic [SLOT_W-1:0] slot;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic              ram_wdata;
   logic              ram_re;
   logic              ram_rdata;

   always_comb begin
      x0      = {32'd0, key_ff};
      mix_t   = x0 ^ (64'(cmd.probe) + HASH_GOLDEN + (x0 << 6) + (x0 >> 2));
      s1_x_in = mix_t ^ (mix_t >> 30);
      prod2   = 64'(s1_x_ff[31:0]) * 64'(HASH_MUL1[31:0]);
      prod3   = 64'(s2_x_ff[31:0]) * 64'(HASH_MUL1[63:32]);
      prod4   = 64'(s3_x_ff[63:32]) * 64'(HASH_MUL1[31:0]);
      x2      = s4_y_ff ^ (s4_y_ff >> 27);
      prod5   = 64'(x2[31:0]) * 64'(HASH_MUL2[31:0]);
      prod6   = 64'(s5_x_ff[31:0]) * 64'(HASH_MUL2[63:32]);
      prod7   = 64'(s6_x_ff[63:32]) * 64'(HASH_MUL2[31:0]);
      z_fin   = s7_z_ff ^ (s7_z_ff >> 31);
      slot    = z_fin[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      s1_x_ff   <= s1_x_in;
      s2_x_ff   <= s1_x_ff;
      s2_acc_ff <= prod2;
      s3_x_ff   <= s2_x_ff;
      s3_acc_ff <= s2_acc_ff + {prod3[31:0], 32'd0};
      s4_y_ff   <= s3_acc_ff + {prod4[31:0], 32'd0};
      s5_x_ff   <= x2;
      s5_acc_ff <= prod5;
      s6_x_ff   <= s5_x_ff;
      s6_acc_ff <= s5_acc_ff + {prod6[31:0], 32'd0};
      s7_z_ff   <= s6_acc_ff + {prod7[31:0], 32'd0};
      if (cmd.accept) begin
         op_ff  <= req_operation;
         key_ff <= req_key;
      end
      if (cmd.load_rsp) begin
         may_ff <= (op_ff == OP_INSERT) ? 1'b1 : hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         clr_addr_ff <= '0;
         hit_ff      <= 1'b1;
      end else begin
         valid_ff    <= {valid_ff[6:1], cmd.issue};
         rd_valid_ff <= ram_re;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
         if (cmd.accept) begin
            hit_ff <= 1'b1;
         end else if (rd_valid_ff) begin
            hit_ff <= hit_ff & ram_rdata;
         end
      end
   end

   always_comb begin
      ram_we    = cmd.clear | (valid_ff[7] & (op_ff == OP_INSERT));
      ram_waddr = cmd.clear ? clr_addr_ff : slot;
      ram_wdata = ~cmd.clear;
      ram_re    = valid_ff[7] & (op_ff == OP_QUERY);
   end

   bfiq_ram #(
      .WIDTH (1),
      .DEPTH (FILTER_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (slot),
      .rd_data (ram_rdata)
   );

   assign status.clear_last = (clr_addr_ff == {SLOT_W{1'b1}});
   assign status.busy       = (|valid_ff) | rd_valid_ff;
   assign rsp_may_contain   = may_ff;

endmodule

### hdl/bfiq_ctrl.sv
// Controller state machine: clearing pass, request acceptance, probe
// sequencing, drain wait and response valid. Depends on bfiq_pkg.
module bfiq_ctrl
   import bfiq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COUNT_W-1:0] probe_count,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  bfiq_status_type    status,
   output bfiq_cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [PROBE_W-1:0] probe_ff;
   logic [PROBE_W-1:0] probe_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [COUNT_W-1:0] probes_eff;
   logic               last_probe;

   always_comb begin
      priority if (probe_count == '0) begin
         probes_eff = COUNT_W'(1);
      end else if (probe_count > COUNT_W'(PROBE_MAX)) begin
         probes_eff = COUNT_W'(PROBE_MAX);
      end else begin
         probes_eff = probe_count;
      end
      last_probe = (COUNT_W'(probe_ff) == probes_eff - COUNT_W'(1));
   end

   always_comb begin
      cmd.clear    = (state_ff == ST_CLEAR);
      cmd.accept   = (state_ff == ST_IDLE) & req_valid;
      cmd.issue    = (state_ff == ST_ISSUE);
      cmd.probe    = probe_ff;
      cmd.load_rsp = (state_ff == ST_DRAIN) & ~status.busy & (~rsp_valid_ff | ~rsp_stall);

      state_in     = state_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
               probe_in = '0;
            end
         end
         ST_ISSUE: begin
            probe_in = probe_ff + PROBE_W'(1);
            if (last_probe) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.load_rsp) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hdl/bloom_filter_insert_query_core.sv
// Top level of the Bloom filter insert/query core: configuration register,
// controller and datapath. Depends on bfiq_pkg, bfiq_ctrl and bfiq_datapath.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_operation, req_key
//   rsp       out        rsp_valid/rsp_stall   rsp_may_contain
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// From acceptance until the core accepts again, an insert or a query issues n probes,
// n being the effective probe count, which then drain through the seven-stage hash
// pipeline and, for a query, the registered read of the bit store.
// After reset the core clears all 1024 bits of the bit store one bit per cycle,
// holding req_stall high; configuration writes are taken during this pass.
// A response waits in its output register; a stall there holds the next one back.
module bloom_filter_insert_query_core
   import bfiq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic signed [31:0] req_key,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_may_contain,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [COUNT_W-1:0] probe_count_ff;
   logic               csr_sel;
   bfiq_cmd_type       cmd;
   bfiq_status_type    status;

   assign csr_sel = (paddr[2] == CSR_IDX_PROBE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_count_ff <= PROBE_COUNT_RESET;
      end else if (psel & penable & pwrite & pready & csr_sel) begin
         probe_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   assign prdata = csr_sel ? {{(32-COUNT_W){1'b0}}, probe_count_ff} : 32'd0;
   assign pready = 1'b1;

   bfiq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .probe_count (probe_count_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   bfiq_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .rsp_may_contain (rsp_may_contain)
   );

endmodule

### hdl/bfiq_checker.sv
// Port-level checker for the Bloom filter insert/query core, attached to
// the top level by the bind statement below. Depends on the top level's ports.
module bfiq_port_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_may_contain
);

   // A stalled response holds its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_may_contain))
      else $error("stalled response changed");

   // The clearing pass keeps requests stalled right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request accepted during clearing pass");

   // An accepted transaction blocks the next one while its probes run.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back-to-back request accepted");

   // A new response appears only as the core returns to accepting requests.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("response raised while core busy");

endmodule

bind bloom_filter_insert_query_core bfiq_port_checker u_bfiq_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_may_contain (rsp_may_contain)
);
